// ----- rtl/core/cfd_pkg.sv -----
// Shared types, constants and helper functions of the checked frame decoder.
package cfd_pkg;

   localparam int unsigned DataWidth     = 8;
   localparam int unsigned WordWidth     = 32;
   localparam int unsigned PosWidth      = 5;
   localparam int unsigned TypeWidth     = 5;
   localparam int unsigned EventWidth    = 2;
   localparam int unsigned ErrWidth      = 3;
   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned QueueDepth    = 4;

   // Header layout (byte positions)
   localparam logic [PosWidth-1:0] PosVersion = 5'd4;
   localparam logic [PosWidth-1:0] PosType    = 5'd5;
   localparam logic [PosWidth-1:0] PosAuth    = 5'd10;
   localparam logic [PosWidth-1:0] PosLen     = 5'd14;
   localparam logic [PosWidth-1:0] PosLenLast = 5'd17;
   localparam logic [PosWidth-1:0] PosSum     = 5'd18;
   localparam logic [PosWidth-1:0] PosSumLast = 5'd21;
   localparam logic [PosWidth-1:0] PosEpoch   = 5'd6;

   localparam logic [DataWidth-1:0] MaxType = 8'd25;

   localparam logic [WordWidth-1:0] FnvBasis = 32'h811C_9DC5;

   localparam logic [DataWidth-1:0] ExpectedVersionReset = 8'd1;
   localparam logic [WordWidth-1:0] MaxPayloadLenReset   = 32'd1048576;

   typedef enum logic [EventWidth-1:0] {
      EvPayload = 2'd0,
      EvAccept  = 2'd1,
      EvReject  = 2'd2
   } event_type;

   typedef enum logic [ErrWidth-1:0] {
      ErrNone     = 3'd0,
      ErrMagic    = 3'd1,
      ErrVersion  = 3'd2,
      ErrType     = 3'd3,
      ErrOversize = 3'd4,
      ErrChecksum = 3'd5
   } err_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CsrExpectedVersion = 1'b0,
      CsrMaxPayloadLen   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [EventWidth-1:0] event_res;
      logic [DataWidth-1:0]  payload_byte;
      logic [TypeWidth-1:0]  msg_type;
      logic [WordWidth-1:0]  epoch;
      logic [WordWidth-1:0]  authority;
      logic [WordWidth-1:0]  payload_len;
      logic [ErrWidth-1:0]   error_code;
      logic                  last;
   } rsp_type;

   // Results produced by one byte, in order: first then second
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   typedef struct packed {
      logic room;   // space for two more results
   } queue_status_type;

   function automatic logic [DataWidth-1:0] magic_byte(input logic [1:0] idx);
      logic [DataWidth-1:0] b;
      case (idx)
         2'd0: b = 8'h45;
         2'd1: b = 8'h52;
         2'd2: b = 8'h46;
         2'd3: b = 8'h46;
         default: b = 8'h45;
      endcase
      return b;
   endfunction

   // FNV-1a step; prime is 2^24 + 0x193, so the product is a sum of shifts
   function automatic logic [WordWidth-1:0] fnv_step(input logic [WordWidth-1:0] h,
                                                     input logic [DataWidth-1:0] b);
      logic [WordWidth-1:0] x;
      x = h ^ {24'd0, b};
      return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
   endfunction

   function automatic logic [WordWidth-1:0] shift_in(input logic [WordWidth-1:0] w,
                                                     input logic [DataWidth-1:0] b);
      return {b, w[WordWidth-1:DataWidth]};
   endfunction

   function automatic rsp_type make_reject(input err_type code);
      rsp_type r;
      r = '0;
      r.event_res  = EvReject;
      r.error_code = code;
      return r;
   endfunction

   function automatic rsp_type make_verdict(input logic                 ok,
                                            input logic [TypeWidth-1:0] ty,
                                            input logic [WordWidth-1:0] ep,
                                            input logic [WordWidth-1:0] au,
                                            input logic [WordWidth-1:0] len);
      rsp_type r;
      if (ok) begin
         r             = '0;
         r.event_res   = EvAccept;
         r.msg_type    = ty;
         r.epoch       = ep;
         r.authority   = au;
         r.payload_len = len;
      end else begin
         r = make_reject(ErrChecksum);
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/cfd_channels.sv -----
// Handshake channel interfaces: byte input, result output, register writes.
interface cfd_req_if;
   logic                           valid;
   logic                           ready;
   logic [cfd_pkg::DataWidth-1:0]  data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface cfd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [cfd_pkg::EventWidth-1:0] event_res;
   logic [cfd_pkg::DataWidth-1:0]  payload_byte;
   logic [cfd_pkg::TypeWidth-1:0]  msg_type;
   logic [cfd_pkg::WordWidth-1:0]  epoch;
   logic [cfd_pkg::WordWidth-1:0]  authority;
   logic [cfd_pkg::WordWidth-1:0]  payload_len;
   logic [cfd_pkg::ErrWidth-1:0]   error_code;
   logic                           last;

   modport source (output valid, output event_res, output payload_byte, output msg_type,
                   output epoch, output authority, output payload_len,
                   output error_code, output last, input ready);
   modport sink   (input valid, input event_res, input payload_byte, input msg_type,
                   input epoch, input authority, input payload_len,
                   input error_code, input last, output ready);
endinterface

interface cfd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [cfd_pkg::CsrIndexWidth-1:0] index;
   logic [cfd_pkg::WordWidth-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/cfd_decode.sv -----
// Input byte register, header/payload parser state and result generation.
module cfd_decode (
   input  logic                      clock,
   input  logic                      reset,
   cfd_req_if.sink                   req,
   cfd_csr_if.sink                   csr,
   input  cfd_pkg::queue_status_type queue_status,
   output cfd_pkg::push_type         push
);

   logic                              in_valid_ff, in_valid_in;
   logic [cfd_pkg::DataWidth-1:0]     in_byte_ff;
   logic                              fire;

   logic [cfd_pkg::DataWidth-1:0]     version_ff;
   logic [cfd_pkg::WordWidth-1:0]     max_len_ff;

   logic [cfd_pkg::PosWidth-1:0]      pos_ff, pos_in;
   logic                              in_payload_ff, in_payload_in;
   logic [cfd_pkg::WordWidth-1:0]     remaining_ff, remaining_in;
   logic [cfd_pkg::TypeWidth-1:0]     type_ff, type_in;
   logic [cfd_pkg::WordWidth-1:0]     epoch_ff, epoch_in;
   logic [cfd_pkg::WordWidth-1:0]     auth_ff, auth_in;
   logic [cfd_pkg::WordWidth-1:0]     len_ff, len_in;
   logic [cfd_pkg::WordWidth-1:0]     sum_ff, sum_in;
   logic [cfd_pkg::WordWidth-1:0]     hash_ff, hash_in;

   assign fire        = in_valid_ff && queue_status.room;
   assign req.ready   = !in_valid_ff || fire;
   assign in_valid_in = (req.valid && req.ready) || (in_valid_ff && !fire);
   assign csr.ready   = 1'b1;

   always_comb begin
      logic [cfd_pkg::DataWidth-1:0] b;
      b             = in_byte_ff;
      pos_in        = pos_ff;
      in_payload_in = in_payload_ff;
      remaining_in  = remaining_ff;
      type_in       = type_ff;
      epoch_in      = epoch_ff;
      auth_in       = auth_ff;
      len_in        = len_ff;
      sum_in        = sum_ff;
      hash_in       = hash_ff;
      push          = '0;

      if (fire) begin
         if (in_payload_ff) begin
            push.first              = '0;
            push.first.event_res    = cfd_pkg::EvPayload;
            push.first.payload_byte = b;
            hash_in                 = cfd_pkg::fnv_step(hash_ff, b);
            remaining_in            = remaining_ff - 32'd1;
            push.count              = 2'd1;
            if (remaining_ff == 32'd1) begin
               push.second   = cfd_pkg::make_verdict(hash_in == sum_ff, type_ff,
                                                     epoch_ff, auth_ff, len_ff);
               push.count    = 2'd2;
               in_payload_in = 1'b0;
               pos_in        = '0;
            end
         end else if (pos_ff < cfd_pkg::PosVersion) begin
            if (b == cfd_pkg::magic_byte(pos_ff[1:0])) begin
               pos_in = pos_ff + 5'd1;
            end else if (pos_ff != '0) begin
               push.first = cfd_pkg::make_reject(cfd_pkg::ErrMagic);
               push.count = 2'd1;
               // a stray first-magic byte restarts the magic
               pos_in     = (b == cfd_pkg::magic_byte(2'd0)) ? 5'd1 : 5'd0;
            end
         end else if (pos_ff == cfd_pkg::PosVersion) begin
            if (b == version_ff) begin
               pos_in = pos_ff + 5'd1;
            end else begin
               push.first = cfd_pkg::make_reject(cfd_pkg::ErrVersion);
               push.count = 2'd1;
               pos_in     = '0;
            end
         end else if (pos_ff == cfd_pkg::PosType) begin
            if (b inside {[8'd1 : cfd_pkg::MaxType]}) begin
               type_in = b[cfd_pkg::TypeWidth-1:0];
               pos_in  = pos_ff + 5'd1;
            end else begin
               push.first = cfd_pkg::make_reject(cfd_pkg::ErrType);
               push.count = 2'd1;
               pos_in     = '0;
            end
         end else if (pos_ff < cfd_pkg::PosAuth) begin
            epoch_in = cfd_pkg::shift_in(epoch_ff, b);
            pos_in   = pos_ff + 5'd1;
         end else if (pos_ff < cfd_pkg::PosLen) begin
            auth_in = cfd_pkg::shift_in(auth_ff, b);
            pos_in  = pos_ff + 5'd1;
         end else if (pos_ff < cfd_pkg::PosSum) begin
            len_in = cfd_pkg::shift_in(len_ff, b);
            pos_in = pos_ff + 5'd1;
            if (pos_ff == cfd_pkg::PosLenLast && len_in > max_len_ff) begin
               push.first = cfd_pkg::make_reject(cfd_pkg::ErrOversize);
               push.count = 2'd1;
               pos_in     = '0;
            end
         end else begin
            sum_in = cfd_pkg::shift_in(sum_ff, b);
            pos_in = pos_ff + 5'd1;
            if (pos_ff == cfd_pkg::PosSumLast) begin
               hash_in = cfd_pkg::FnvBasis;
               pos_in  = '0;
               if (len_ff == '0) begin
                  // empty payload: verdict against the hash of nothing
                  push.first = cfd_pkg::make_verdict(sum_in == cfd_pkg::FnvBasis, type_ff,
                                                     epoch_ff, auth_ff, len_ff);
                  push.count = 2'd1;
               end else begin
                  in_payload_in = 1'b1;
                  remaining_in  = len_ff;
               end
            end
         end
      end

      push.first.last  = (push.count == 2'd1);
      push.second.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         pos_ff        <= '0;
         in_payload_ff <= 1'b0;
         remaining_ff  <= '0;
         version_ff    <= cfd_pkg::ExpectedVersionReset;
         max_len_ff    <= cfd_pkg::MaxPayloadLenReset;
      end else begin
         in_valid_ff   <= in_valid_in;
         pos_ff        <= pos_in;
         in_payload_ff <= in_payload_in;
         remaining_ff  <= remaining_in;
         if (csr.valid && csr.index == cfd_pkg::CsrExpectedVersion) begin
            version_ff <= csr.data[cfd_pkg::DataWidth-1:0];
         end
         if (csr.valid && csr.index == cfd_pkg::CsrMaxPayloadLen) begin
            max_len_ff <= csr.data;
         end
      end
   end

   // Header fields and hash: always written before they are read
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.data_byte;
      end
      type_ff  <= type_in;
      epoch_ff <= epoch_in;
      auth_ff  <= auth_in;
      len_ff   <= len_in;
      sum_ff   <= sum_in;
      hash_ff  <= hash_in;
   end

endmodule

// ----- rtl/core/cfd_rsp_queue.sv -----
// Small result queue: takes up to two results a cycle, hands out one.
module cfd_rsp_queue #(
   parameter int unsigned Depth = cfd_pkg::QueueDepth
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cfd_pkg::push_type         push,
   output cfd_pkg::queue_status_type queue_status,
   cfd_rsp_if.source                 rsp
);

   localparam int unsigned IdxW = $clog2(Depth);
   localparam int unsigned CntW = $clog2(Depth + 1);

   cfd_pkg::rsp_type    entries_ff [Depth];
   logic [IdxW-1:0]     head_ff, head_in;
   logic [IdxW-1:0]     tail_ff, tail_in;
   logic [IdxW-1:0]     tail_next;
   logic [CntW-1:0]     count_ff, count_in;
   logic                pop;
   cfd_pkg::rsp_type    head_entry;

   function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] p);
      logic [IdxW-1:0] q;
      if (p == IdxW'(Depth - 1)) begin
         q = '0;
      end else begin
         q = p + 1'b1;
      end
      return q;
   endfunction

   assign pop       = rsp.valid && rsp.ready;
   assign tail_next = wrap_inc(tail_ff);
   assign head_in   = pop ? wrap_inc(head_ff) : head_ff;
   assign count_in  = count_ff + CntW'(push.count) - CntW'(pop);
   assign queue_status.room = (count_ff <= CntW'(Depth - 2));

   always_comb begin
      case (push.count)
         2'd1:    tail_in = tail_next;
         2'd2:    tail_in = wrap_inc(tail_next);
         default: tail_in = tail_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[tail_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[tail_next] <= push.second;
      end
   end

   assign head_entry       = entries_ff[head_ff];
   assign rsp.valid        = (count_ff != '0);
   assign rsp.event_res    = head_entry.event_res;
   assign rsp.payload_byte = head_entry.payload_byte;
   assign rsp.msg_type     = head_entry.msg_type;
   assign rsp.epoch        = head_entry.epoch;
   assign rsp.authority    = head_entry.authority;
   assign rsp.payload_len  = head_entry.payload_len;
   assign rsp.error_code   = head_entry.error_code;
   assign rsp.last         = head_entry.last;

endmodule

// ----- rtl/core/checked_frame_decoder_top.sv -----
// Top level of the checked frame decoder: parser plus result queue.
//
//  channel   dir  transaction                       payload
//  req_chan  in   one stream byte                   data_byte
//  rsp_chan  out  one result (payload or verdict)   event_res .. last
//  csr_chan  in   one register write                index, data
//
// One byte is accepted per cycle while the queue has room for two more results. A byte
// is registered at acceptance, parsed from that register and its results (zero, one
// or two) are written to the result queue, whose head drives the output. The final
// payload byte yields two transactions; the output side moves one per cycle while
// the receiver is ready, and the queue absorbs the extra one. Input stalls only when
// the queue cannot take two more results. Reset is synchronous; there is no clearing
// pass.
module checked_frame_decoder_top #(
   parameter int unsigned RSP_DEPTH = cfd_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   cfd_req_if.sink     req_chan,
   cfd_rsp_if.source   rsp_chan,
   cfd_csr_if.sink     csr_chan
);

   cfd_pkg::push_type         push;
   cfd_pkg::queue_status_type queue_status;

   // Parser: input register, header checks, payload hashing
   cfd_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .csr          (csr_chan),
      .queue_status (queue_status),
      .push         (push)
   );

   // Result queue, also the output register
   cfd_rsp_queue #(
      .Depth (RSP_DEPTH)
   ) u_rsp_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .queue_status (queue_status),
      .rsp          (rsp_chan)
   );

   // An accept verdict carries a real type and no error code
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.event_res == cfd_pkg::EvAccept
         |-> rsp_chan.error_code == cfd_pkg::ErrNone && rsp_chan.msg_type != '0)
      else $error("accept verdict with error code or empty type");

   // A reject carries an error code, a zero payload length and the last flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.event_res == cfd_pkg::EvReject
         |-> rsp_chan.error_code != cfd_pkg::ErrNone && rsp_chan.payload_len == '0
             && rsp_chan.last)
      else $error("malformed reject transaction");

   // Payload bytes never carry an error code or a message type
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.event_res == cfd_pkg::EvPayload
         |-> rsp_chan.error_code == cfd_pkg::ErrNone && rsp_chan.msg_type == '0)
      else $error("payload transaction with header fields");

   // Queue is empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result pending after reset");

endmodule
